FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the slot allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// cond must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: rtl/core/mpsa_pkg.sv
// ----------------------------------------------------------------------------
// mpsa_pkg
// Types, codes and constants shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package mpsa_pkg;

	// default sizing
	localparam int NUM_POOLS_DEF = 4;
	localparam int MAX_SLOTS_DEF = 64;

	// number of capacity registers in the register map
	localparam int CAP_REGS   = 4;
	localparam int CAP_SEL_W  = 2;

	// field widths
	localparam int CMD_W      = 2;
	localparam int POOL_W     = 3;
	localparam int ID_W       = 16;
	localparam int SLOT_W     = 6;
	localparam int STATUS_W   = 3;
	localparam int GRANT_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int CAP_REG_W  = 7;
	localparam int POOLS_REG_W = 3;

	// capacity width inside the block, wide enough for the largest table size
	localparam int CAP_W      = 11;

	// stream widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = CMD_W;
	localparam int OUT_DATA_W = 48;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_POOLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAP2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAP3  = 3'd4;

	localparam logic [POOLS_REG_W-1:0] POOLS_RST = 3'd4;
	localparam logic [CAP_REG_W-1:0]   CAP_RST   = 7'd64;

	// commands
	localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd4;

	// command queue depth
	localparam int QUEUE_DEPTH = 2;

	// class assigned by the front end
	typedef enum logic [2:0] {
		KIND_BAD_POOL,
		KIND_REJECT,
		KIND_RESERVE,
		KIND_RELEASE,
		KIND_QUERY
	} kind_t;

	// classified command handed to the back end
	typedef struct packed {
		kind_t              kind;
		logic [POOL_W-1:0]  pool;
		logic [ID_W-1:0]    id;
		logic [SLOT_W-1:0]  slot;
		logic [CAP_W-1:0]   cap;
	} entry_t;

	typedef logic [CAP_REGS-1:0][CAP_REG_W-1:0] cap_regs_t;

endpackage

FILE: rtl/core/mpsa_front.sv
// ----------------------------------------------------------------------------
// mpsa_front
// Accepts commands, checks pool, id and slot ranges and queues a classified
// entry for the back end.
// ----------------------------------------------------------------------------
module mpsa_front #(
	parameter int NUM_POOLS = mpsa_pkg::NUM_POOLS_DEF,
	parameter int MAX_SLOTS = mpsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pool[2:0], owner_id[18:3], slot[24:19], zero fill above
	input  logic [mpsa_pkg::IN_DATA_W-1:0]      s_tdata,
	// command[1:0]
	input  logic [mpsa_pkg::IN_USER_W-1:0]      s_tuser,
	input  logic [mpsa_pkg::POOLS_REG_W-1:0]    pools_cfg,
	input  mpsa_pkg::cap_regs_t                 cap_cfg,
	input  logic                                clear_busy,
	input  logic                                queue_full,
	output logic                                push,
	output mpsa_pkg::entry_t                    entry
);

	localparam int PC_W = 5;

	logic [mpsa_pkg::CMD_W-1:0]  command;
	logic [mpsa_pkg::POOL_W-1:0] pool;
	logic [mpsa_pkg::ID_W-1:0]   owner_id;
	logic [mpsa_pkg::SLOT_W-1:0] slot;
	logic [PC_W-1:0]             pools_ext;
	logic [PC_W-1:0]             pools_eff;
	logic                        pool_ok;
	logic [mpsa_pkg::CAP_W-1:0]  cap_raw;
	logic [mpsa_pkg::CAP_W-1:0]  cap_eff;
	logic                        slot_ok;

	// field unpacking
	assign command  = s_tuser[mpsa_pkg::CMD_W-1:0];
	assign pool     = s_tdata[2:0];
	assign owner_id = s_tdata[18:3];
	assign slot     = s_tdata[24:19];

	// pool range check, register value saturated at the pool count
	assign pools_ext = PC_W'(pools_cfg);
	assign pools_eff = (pools_ext > PC_W'(NUM_POOLS)) ? PC_W'(NUM_POOLS) : pools_ext;
	assign pool_ok   = PC_W'(pool) < pools_eff;

	// effective capacity, saturated at the table size
	assign cap_raw = (PC_W'(pool) < PC_W'(mpsa_pkg::CAP_REGS)) ?
		mpsa_pkg::CAP_W'(cap_cfg[pool[mpsa_pkg::CAP_SEL_W-1:0]]) :
		mpsa_pkg::CAP_W'(MAX_SLOTS);
	assign cap_eff = (cap_raw > mpsa_pkg::CAP_W'(MAX_SLOTS)) ?
		mpsa_pkg::CAP_W'(MAX_SLOTS) : cap_raw;
	assign slot_ok = mpsa_pkg::CAP_W'(slot) < cap_eff;

	// classification
	always_comb begin
		entry.pool = pool;
		entry.id   = owner_id;
		entry.slot = slot;
		entry.cap  = cap_eff;
		entry.kind = mpsa_pkg::KIND_REJECT;
		if (!pool_ok) begin
			entry.kind = mpsa_pkg::KIND_BAD_POOL;
		end else begin
			case (command)
				mpsa_pkg::CMD_RESERVE: begin
					entry.kind = (owner_id != '0) ? mpsa_pkg::KIND_RESERVE :
						mpsa_pkg::KIND_REJECT;
				end
				mpsa_pkg::CMD_RELEASE: begin
					entry.kind = slot_ok ? mpsa_pkg::KIND_RELEASE : mpsa_pkg::KIND_REJECT;
				end
				mpsa_pkg::CMD_QUERY: begin
					entry.kind = slot_ok ? mpsa_pkg::KIND_QUERY : mpsa_pkg::KIND_REJECT;
				end
				default: begin
					entry.kind = mpsa_pkg::KIND_REJECT;
				end
			endcase
		end
	end

	// handshake: hold off while the queue is full or the table is being cleared
	assign s_tready = !queue_full && !clear_busy;
	assign push     = s_tvalid && s_tready;

endmodule

FILE: rtl/core/mpsa_fifo.sv
// ----------------------------------------------------------------------------
// mpsa_fifo
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpsa_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mpsa_pkg::entry_t  wr_entry,
	input  logic              pop,
	output mpsa_pkg::entry_t  head,
	output logic              full,
	output logic              empty
);

	localparam int DEPTH = mpsa_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mpsa_pkg::entry_t   buf_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = buf_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "push into full queue")
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "pop from empty queue")
	`ASSERT_AT(a_cnt_step, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "fill count did not advance on push")

endmodule

FILE: rtl/core/mpsa_back.sv
// ----------------------------------------------------------------------------
// mpsa_back
// Executes queued commands against the slot table memory, keeps the
// per-pool occupancy counts and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpsa_back #(
	parameter int NUM_POOLS = mpsa_pkg::NUM_POOLS_DEF,
	parameter int MAX_SLOTS = mpsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mpsa_pkg::entry_t                   head,
	input  logic                               empty,
	output logic                               pop,
	output logic                               clear_busy,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status[2:0], slot_granted[8:3], occupant[24:9], free_slots[31:25],
	// used_slots[38:32], pool_capacity[45:39], zero fill above
	output logic [mpsa_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int DEPTH = NUM_POOLS * MAX_SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int CW    = mpsa_pkg::CAP_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WAIT,
		ST_SCAN,
		ST_RESV_END,
		ST_DONE
	} state_t;

	state_t                            state_q;
	mpsa_pkg::entry_t                  cur_q;
	logic [AW-1:0]                     clr_idx_q;
	logic [CNT_W-1:0]                  cnt_q [NUM_POOLS];
	logic [CNT_W-1:0]                  scan_idx_q;
	logic [IDX_W-1:0]                  proc_idx_q;
	logic                              pend_q;
	logic                              found_q;
	logic                              dup_q;
	logic [IDX_W-1:0]                  first_q;
	logic [mpsa_pkg::STATUS_W-1:0]     status_q;
	logic [mpsa_pkg::GRANT_W-1:0]      granted_q;
	logic [mpsa_pkg::ID_W-1:0]         occ_q;
	logic                              m_tvalid_q;
	logic [mpsa_pkg::OUT_DATA_W-1:0]   m_tdata_q;

	logic [mpsa_pkg::ID_W-1:0]         mem [DEPTH];
	logic [mpsa_pkg::ID_W-1:0]         rdata_q;
	logic                              mem_we;
	logic                              mem_re;
	logic [AW-1:0]                     mem_addr;
	logic [mpsa_pkg::ID_W-1:0]         mem_wdata;

	logic [PW-1:0]                     pool_idx;
	logic [AW-1:0]                     base;
	logic [AW-1:0]                     slot_addr;
	logic [CNT_W-1:0]                  cnt_cur;
	logic [CW-1:0]                     cnt_ext;
	logic [CW-1:0]                     free_cnt;
	logic                              scan_more;
	logic                              bad_pool;
	logic                              out_free;

	// addressing of the current pool
	assign pool_idx  = PW'(cur_q.pool);
	assign base      = AW'((AW + 1)'(pool_idx) * (AW + 1)'(MAX_SLOTS));
	assign slot_addr = base + AW'(IDX_W'(cur_q.slot));
	assign cnt_cur   = cnt_q[pool_idx];
	assign cnt_ext   = CW'(cnt_cur);
	assign free_cnt  = (cnt_ext >= cur_q.cap) ? '0 : cur_q.cap - cnt_ext;
	assign scan_more = CW'(scan_idx_q) < cur_q.cap;
	assign bad_pool  = cur_q.kind == mpsa_pkg::KIND_BAD_POOL;
	assign out_free  = !m_tvalid_q || m_tready;

	assign pop        = (state_q == ST_IDLE) && !empty;
	assign clear_busy = state_q == ST_CLEAR;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = slot_addr;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_idx_q;
			end
			ST_DECODE: begin
				mem_re = (cur_q.kind == mpsa_pkg::KIND_RELEASE) ||
					(cur_q.kind == mpsa_pkg::KIND_QUERY);
			end
			ST_WAIT: begin
				mem_we = (cur_q.kind == mpsa_pkg::KIND_RELEASE) && (rdata_q != '0);
			end
			ST_SCAN: begin
				mem_re   = scan_more;
				mem_addr = base + AW'(scan_idx_q);
			end
			ST_RESV_END: begin
				mem_we    = !dup_q && found_q;
				mem_addr  = base + AW'(first_q);
				mem_wdata = cur_q.id;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// slot table, single port with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// sequencer, occupancy counts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int p = 0; p < NUM_POOLS; p++) begin
				cnt_q[p] <= '0;
			end
		end else begin
			// in ST_DONE a taken result is replaced by the next one below
			if (m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						cur_q   <= head;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					status_q   <= mpsa_pkg::STATUS_INVALID;
					granted_q  <= '0;
					occ_q      <= '0;
					scan_idx_q <= '0;
					pend_q     <= 1'b0;
					found_q    <= 1'b0;
					dup_q      <= 1'b0;
					first_q    <= '0;
					case (cur_q.kind)
						mpsa_pkg::KIND_RESERVE: begin
							if (cnt_ext >= cur_q.cap) begin
								status_q <= mpsa_pkg::STATUS_FULL;
								state_q  <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						mpsa_pkg::KIND_RELEASE, mpsa_pkg::KIND_QUERY: begin
							state_q <= ST_WAIT;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WAIT: begin
					if (cur_q.kind == mpsa_pkg::KIND_QUERY) begin
						occ_q    <= rdata_q;
						status_q <= mpsa_pkg::STATUS_OK;
					end else if (rdata_q == '0) begin
						status_q <= mpsa_pkg::STATUS_EMPTY;
					end else begin
						occ_q    <= rdata_q;
						status_q <= mpsa_pkg::STATUS_OK;
						if (cnt_cur != '0) begin
							cnt_q[pool_idx] <= cnt_cur - CNT_W'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					// check the entry read in the previous cycle
					if (pend_q) begin
						if (!found_q && (rdata_q == '0)) begin
							found_q <= 1'b1;
							first_q <= proc_idx_q;
						end
						if (rdata_q == cur_q.id) begin
							dup_q <= 1'b1;
						end
					end
					// issue the next read
					if (scan_more) begin
						proc_idx_q <= IDX_W'(scan_idx_q);
						scan_idx_q <= scan_idx_q + CNT_W'(1);
						pend_q     <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_RESV_END;
						end
					end
				end
				ST_RESV_END: begin
					if (dup_q) begin
						status_q <= mpsa_pkg::STATUS_DUP;
					end else if (!found_q) begin
						status_q <= mpsa_pkg::STATUS_FULL;
					end else begin
						status_q        <= mpsa_pkg::STATUS_OK;
						granted_q       <= mpsa_pkg::GRANT_W'(first_q);
						cnt_q[pool_idx] <= cnt_cur + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {
							2'b00,
							bad_pool ? 7'd0 : 7'(cur_q.cap),
							bad_pool ? 7'd0 : 7'(cnt_cur),
							bad_pool ? 7'd0 : 7'(free_cnt),
							occ_q,
							granted_q,
							status_q
						};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_no_pop_clear, clk, arst_n, clear_busy && pop, "command taken during table clear")
	`ASSERT_AT(a_write_states, clk, arst_n, mem_we |-> (state_q == ST_CLEAR || state_q == ST_WAIT || state_q == ST_RESV_END), "table written outside a write step")
	`ASSERT_AT(a_scan_bound, clk, arst_n, (state_q == ST_SCAN) |-> (CW'(scan_idx_q) <= cur_q.cap), "scan ran past pool capacity")

endmodule

FILE: rtl/core/multi_pool_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// multi_pool_slot_allocator_unit
// Owner-tagged slot allocator over several pools, with first-fit reserve.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (command in s_tuser, pool, owner id and
// slot in s_tdata); one result transaction per command leaves on the m_
// stream. Registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the block is idle, and the block itself
// does not enforce this. Index 0 is the number of pools in use, 1 to 4 the
// pool capacities. A front end classifies each command and places it in a
// two-entry queue, so new commands are taken while the back end works on
// an earlier one. The back end runs one command at a time on a single-port
// slot table. Release and query read the addressed entry (a release then
// clears an occupied one); reserve scans the pool's usable slots one read
// per cycle, then writes the owner id into the first free slot unless the
// id is already in the pool. After reset the table is cleared, one entry
// per cycle, over all NUM_POOLS * MAX_SLOTS entries (256 by default);
// s_tready stays low until then. When m_tready is low the result is held
// and the back end waits, and the queue fills before s_tready drops.
// ----------------------------------------------------------------------------
module multi_pool_slot_allocator_unit #(
	parameter int NUM_POOLS = mpsa_pkg::NUM_POOLS_DEF,
	parameter int MAX_SLOTS = mpsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pool[2:0], owner_id[18:3], slot[24:19], zero fill above
	input  logic [mpsa_pkg::IN_DATA_W-1:0]      s_tdata,
	// command[1:0]
	input  logic [mpsa_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[2:0], slot_granted[8:3], occupant[24:9], free_slots[31:25],
	// used_slots[38:32], pool_capacity[45:39], zero fill above
	output logic [mpsa_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic [mpsa_pkg::POOLS_REG_W-1:0] pools_q;
	mpsa_pkg::cap_regs_t              caps_q;
	logic                             push;
	logic                             pop;
	logic                             queue_full;
	logic                             queue_empty;
	logic                             clear_busy;
	mpsa_pkg::entry_t                 wr_entry;
	mpsa_pkg::entry_t                 head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pools_q <= mpsa_pkg::POOLS_RST;
			for (int i = 0; i < mpsa_pkg::CAP_REGS; i++) begin
				caps_q[i] <= mpsa_pkg::CAP_RST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				mpsa_pkg::REG_POOLS: pools_q   <= cfg_data[mpsa_pkg::POOLS_REG_W-1:0];
				mpsa_pkg::REG_CAP0:  caps_q[0] <= cfg_data;
				mpsa_pkg::REG_CAP1:  caps_q[1] <= cfg_data;
				mpsa_pkg::REG_CAP2:  caps_q[2] <= cfg_data;
				mpsa_pkg::REG_CAP3:  caps_q[3] <= cfg_data;
				default: begin
					pools_q <= pools_q;
				end
			endcase
		end
	end

	// command intake and classification
	mpsa_front #(
		.NUM_POOLS (NUM_POOLS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.pools_cfg  (pools_q),
		.cap_cfg    (caps_q),
		.clear_busy (clear_busy),
		.queue_full (queue_full),
		.push       (push),
		.entry      (wr_entry)
	);

	// queue between front and back
	mpsa_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	// table access and results
	mpsa_back #(
		.NUM_POOLS (NUM_POOLS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (queue_empty),
		.pop        (pop),
		.clear_busy (clear_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
